// ===== hw/rtl/wcpl_pkg.sv =====
// shared constants, types and the buffer-energy factor table of the wheel current limiter
package wcpl_pkg;

   localparam int FB       = 16;
   localparam int FW       = FB + 1;
   localparam int ERR_W    = 17;
   localparam int MAG_W    = 16;
   localparam int SUM_W    = 18;
   localparam int CUR_W    = 16;
   localparam int QUO_W    = 16;
   localparam int LANES    = 4;
   localparam int LANE_LAT = QUO_W + 2;
   localparam int LAT      = (FB + 1) + 2 + LANE_LAT;

   localparam logic [FW-1:0] FX_ONE  = FW'(64'd1 << FB);
   localparam logic [FW-1:0] FX_P90  = FW'(((64'd9 << FB) + 64'd5) / 64'd10);
   localparam logic [FW-1:0] FX_P75  = FW'((64'd3 << FB) / 64'd4);
   localparam logic [FW-1:0] FX_P50  = FW'((64'd1 << FB) / 64'd2);
   localparam logic [FW-1:0] FX_P25  = FW'((64'd1 << FB) / 64'd4);
   localparam logic [FW-1:0] FX_P125 = FW'((64'd1 << FB) / 64'd8);
   localparam logic [FW-1:0] FX_P05  = FW'(((64'd1 << FB) + 64'd10) / 64'd20);

   localparam logic [1:0] CSR_TOTAL_ERROR_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_POWER_THRESHOLD    = 2'd1;
   localparam logic [1:0] CSR_FULL_SCALE_CURRENT = 2'd2;

   localparam logic [17:0] RST_TOTAL_ERROR_LIMIT  = 18'd20000;
   localparam logic [11:0] RST_POWER_THRESHOLD    = 12'd600;
   localparam logic [15:0] RST_FULL_SCALE_CURRENT = 16'd61536;

   typedef struct packed {
      logic [LANES-1:0][ERR_W-1:0] err;
      logic [SUM_W-1:0]            sum;
      logic [FW-1:0]               pfac;
      logic                        bypass;
   } item_type;

   function automatic logic [FW-1:0] buffer_factor(input logic [9:0] buf_e);
      logic [FW-1:0] f;
      f = FX_ONE;
      if (buf_e inside {[10'd40:10'd49]}) f = FX_P90;
      else if (buf_e inside {[10'd35:10'd39]}) f = FX_P75;
      else if (buf_e inside {[10'd30:10'd34]}) f = FX_P50;
      else if (buf_e inside {[10'd20:10'd29]}) f = FX_P25;
      else if (buf_e inside {[10'd10:10'd19]}) f = FX_P125;
      else if (buf_e inside {[10'd1:10'd9]}) f = FX_P05;
      return f;
   endfunction

endpackage

// ===== hw/rtl/wcpl_kdiv.sv =====
// pipelined restoring divider for the overall gain, one quotient bit per stage
module wcpl_kdiv (
   input  logic                     clock,
   input  logic                     en,
   input  wcpl_pkg::item_type       item_in,
   input  logic [17:0]              limit,
   output wcpl_pkg::item_type       item_out,
   output logic [wcpl_pkg::FW-1:0]  k
);

   logic [wcpl_pkg::SUM_W-1:0] rem_ff  [0:wcpl_pkg::FB];
   logic [wcpl_pkg::SUM_W-1:0] rem_in  [0:wcpl_pkg::FB];
   logic [wcpl_pkg::FB-1:0]    q_ff    [0:wcpl_pkg::FB];
   logic [wcpl_pkg::FB-1:0]    q_in    [0:wcpl_pkg::FB];
   logic                       full_ff [0:wcpl_pkg::FB];
   logic                       full_in [0:wcpl_pkg::FB];
   wcpl_pkg::item_type         item_ff [0:wcpl_pkg::FB];
   wcpl_pkg::item_type         item_in_s [0:wcpl_pkg::FB];

   always_comb begin
      rem_in[0]    = item_in.sum;
      q_in[0]      = '0;
      full_in[0]   = item_in.sum >= limit;
      item_in_s[0] = item_in;
   end

   for (genvar s = 1; s <= wcpl_pkg::FB; s++) begin : g_step
      logic [wcpl_pkg::SUM_W:0] t;
      logic                     ge;
      always_comb begin
         t            = {rem_ff[s-1], 1'b0};
         ge           = t >= {1'b0, limit};
         rem_in[s]    = ge ? wcpl_pkg::SUM_W'(t - {1'b0, limit}) : t[wcpl_pkg::SUM_W-1:0];
         q_in[s]      = {q_ff[s-1][wcpl_pkg::FB-2:0], ge};
         full_in[s]   = full_ff[s-1];
         item_in_s[s] = item_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= wcpl_pkg::FB; s++) begin
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
            full_ff[s] <= full_in[s];
            item_ff[s] <= item_in_s[s];
         end
      end
   end

   assign item_out = item_ff[wcpl_pkg::FB];
   assign k = full_ff[wcpl_pkg::FB] ? wcpl_pkg::FX_ONE : {1'b0, q_ff[wcpl_pkg::FB]};

endmodule

// ===== hw/rtl/wcpl_lane.sv =====
// one wheel lane: error times gain, divided by the summed error, then saturated
module wcpl_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic [wcpl_pkg::ERR_W-1:0]    err,
   input  logic [15:0]                   gain,
   input  logic [wcpl_pkg::SUM_W-1:0]    sum,
   input  logic                          kill,
   output logic signed [wcpl_pkg::CUR_W-1:0] current
);

   localparam int D = wcpl_pkg::QUO_W;

   logic [wcpl_pkg::SUM_W-1:0] rem_ff  [0:D];
   logic [wcpl_pkg::SUM_W-1:0] rem_in  [0:D];
   logic [D-1:0]               lq_ff   [0:D];
   logic [D-1:0]               lq_in   [0:D];
   logic [wcpl_pkg::SUM_W-1:0] sum_ff  [0:D];
   logic [wcpl_pkg::SUM_W-1:0] sum_in  [0:D];
   logic                       neg_ff  [0:D];
   logic                       neg_in  [0:D];
   logic                       kill_ff [0:D];
   logic                       kill_in [0:D];
   logic signed [wcpl_pkg::CUR_W-1:0] current_ff;
   logic signed [wcpl_pkg::CUR_W-1:0] current_in;

   logic [wcpl_pkg::ERR_W-1:0] err_abs;
   logic [wcpl_pkg::MAG_W-1:0] mag;
   logic [31:0]                prod;

   always_comb begin
      err_abs    = err[wcpl_pkg::ERR_W-1] ? wcpl_pkg::ERR_W'(-err) : err;
      mag        = err_abs[wcpl_pkg::MAG_W-1:0];
      prod       = 32'(mag) * 32'(gain);
      rem_in[0]  = wcpl_pkg::SUM_W'(prod[31:D]);
      lq_in[0]   = prod[D-1:0];
      sum_in[0]  = sum;
      neg_in[0]  = err[wcpl_pkg::ERR_W-1];
      kill_in[0] = kill;
   end

   for (genvar s = 1; s <= D; s++) begin : g_step
      logic [wcpl_pkg::SUM_W:0] t;
      logic                     ge;
      always_comb begin
         t          = {rem_ff[s-1], lq_ff[s-1][D-1]};
         ge         = t >= {1'b0, sum_ff[s-1]};
         rem_in[s]  = ge ? wcpl_pkg::SUM_W'(t - {1'b0, sum_ff[s-1]})
                         : t[wcpl_pkg::SUM_W-1:0];
         lq_in[s]   = {lq_ff[s-1][D-2:0], ge};
         sum_in[s]  = sum_ff[s-1];
         neg_in[s]  = neg_ff[s-1];
         kill_in[s] = kill_ff[s-1];
      end
   end

   always_comb begin
      if (kill_ff[D]) begin
         current_in = '0;
      end else if (neg_ff[D]) begin
         current_in = (lq_ff[D] > 16'd32768) ? -16'sd32768
                                            : wcpl_pkg::CUR_W'(-lq_ff[D]);
      end else begin
         current_in = (lq_ff[D] > 16'd32767) ? 16'sd32767 : $signed(lq_ff[D]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= D; s++) begin
            rem_ff[s]  <= rem_in[s];
            lq_ff[s]   <= lq_in[s];
            sum_ff[s]  <= sum_in[s];
            neg_ff[s]  <= neg_in[s];
            kill_ff[s] <= kill_in[s];
         end
         current_ff <= current_in;
      end
   end

   assign current = current_ff;

endmodule

// ===== hw/rtl/wheel_current_power_limiter.sv =====
// top level of the wheel current limiter: config registers, gain stages and four lanes
//
// request channel: req_valid / req_stall with four targets, four rotor speeds,
// power and buffer energy in one beat. response channel: rsp_valid / rsp_stall
// with four saturated currents and the bypass flag, one response beat per
// request beat, in order.
// pipeline: an entry register and a register per quotient bit in the gain divider,
// two multiply stages, then per lane one multiply stage, 16 divide stages and a
// saturation register.
// throughput is one beat per cycle while no response beat is stalled; all stages advance together.
// csr_we writes csr_wdata into the register chosen by csr_index; writes are
// expected only while the pipeline is empty.
// reset restores the register defaults and empties the pipeline.
// while a response beat is stalled the whole pipeline holds and req_stall is
// raised, so nothing is dropped.
module wheel_current_power_limiter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_target_a,
   input  logic signed [15:0] req_target_b,
   input  logic signed [15:0] req_target_c,
   input  logic signed [15:0] req_target_d,
   input  logic signed [15:0] req_rotor_a,
   input  logic signed [15:0] req_rotor_b,
   input  logic signed [15:0] req_rotor_c,
   input  logic signed [15:0] req_rotor_d,
   input  logic [11:0]        req_power_now,
   input  logic [9:0]         req_buffer_energy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_current_a,
   output logic signed [15:0] rsp_current_b,
   output logic signed [15:0] rsp_current_c,
   output logic signed [15:0] rsp_current_d,
   output logic               rsp_bypass,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [17:0]        csr_wdata
);

   localparam int FB = wcpl_pkg::FB;
   localparam int FW = wcpl_pkg::FW;

   logic [17:0] limit_ff;
   logic [11:0] thresh_ff;
   logic [15:0] fsc_ff;

   logic en;
   logic accept;
   logic vld_ff [0:wcpl_pkg::LAT-1];
   logic byp_ff [0:wcpl_pkg::LANE_LAT-1];

   logic signed [15:0] tgt [0:3];
   logic signed [15:0] rot [0:3];
   wcpl_pkg::item_type item_s;

   wcpl_pkg::item_type kd_item;
   logic [FW-1:0]      kd_k;

   logic [15+FW:0]     a_prod;
   logic [15:0]        a_ff;
   logic [15:0]        a_in;
   wcpl_pkg::item_type a_item_ff;
   logic [15+FW:0]     b_prod;
   logic [15:0]        b_ff;
   logic [15:0]        b_in;
   wcpl_pkg::item_type b_item_ff;

   logic signed [15:0] cur [0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= wcpl_pkg::RST_TOTAL_ERROR_LIMIT;
         thresh_ff <= wcpl_pkg::RST_POWER_THRESHOLD;
         fsc_ff    <= wcpl_pkg::RST_FULL_SCALE_CURRENT;
      end else if (csr_we) begin
         case (csr_index)
            wcpl_pkg::CSR_TOTAL_ERROR_LIMIT:  limit_ff  <= csr_wdata;
            wcpl_pkg::CSR_POWER_THRESHOLD:    thresh_ff <= csr_wdata[11:0];
            wcpl_pkg::CSR_FULL_SCALE_CURRENT: fsc_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   always_comb begin
      logic signed [16:0] e;
      logic [16:0]        ea;
      logic [17:0]        acc;
      tgt[0] = req_target_a; tgt[1] = req_target_b;
      tgt[2] = req_target_c; tgt[3] = req_target_d;
      rot[0] = req_rotor_a;  rot[1] = req_rotor_b;
      rot[2] = req_rotor_c;  rot[3] = req_rotor_d;
      acc = '0;
      item_s.err = '0;
      for (int i = 0; i < 4; i++) begin
         e  = 17'(tgt[i]) - 17'(rot[i]);
         ea = e[16] ? 17'(-e) : 17'(e);
         item_s.err[i] = e;
         acc = acc + 18'(ea);
      end
      item_s.sum    = acc;
      item_s.pfac   = wcpl_pkg::buffer_factor(req_buffer_energy);
      item_s.bypass = req_power_now > thresh_ff;
   end

   wcpl_kdiv u_kdiv (
      .clock    (clock),
      .en       (en),
      .item_in  (item_s),
      .limit    (limit_ff),
      .item_out (kd_item),
      .k        (kd_k)
   );

   always_comb begin
      a_prod = (16+FW)'(fsc_ff) * (16+FW)'(kd_k);
      a_in   = a_prod[FB+15:FB];
      b_prod = (16+FW)'(a_ff) * (16+FW)'(a_item_ff.pfac);
      b_in   = b_prod[FB+15:FB];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= a_in;
         a_item_ff <= kd_item;
         b_ff      <= b_in;
         b_item_ff <= a_item_ff;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      wcpl_lane u_lane (
         .clock   (clock),
         .en      (en),
         .err     (b_item_ff.err[i]),
         .gain    (b_ff),
         .sum     (b_item_ff.sum),
         .kill    (b_item_ff.bypass || (b_item_ff.sum == '0)),
         .current (cur[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < wcpl_pkg::LAT; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= accept;
         for (int s = 1; s < wcpl_pkg::LAT; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         byp_ff[0] <= b_item_ff.bypass;
         for (int s = 1; s < wcpl_pkg::LANE_LAT; s++) byp_ff[s] <= byp_ff[s-1];
      end
   end

   assign rsp_valid     = vld_ff[wcpl_pkg::LAT-1];
   assign rsp_bypass    = byp_ff[wcpl_pkg::LANE_LAT-1];
   assign rsp_current_a = cur[0];
   assign rsp_current_b = cur[1];
   assign rsp_current_c = cur[2];
   assign rsp_current_d = cur[3];

   a_bypass_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bypass |-> (rsp_current_a == 16'sd0) && (rsp_current_b == 16'sd0)
                                  && (rsp_current_c == 16'sd0) && (rsp_current_d == 16'sd0))
      else $error("bypass beat with nonzero current");

   a_gain_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[wcpl_pkg::FB] |-> kd_k <= wcpl_pkg::FX_ONE)
      else $error("gain above one");

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted beat not in pipeline");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_current_a) && $stable(rsp_bypass))
      else $error("stalled response changed");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the wheel current limiter: random beats, csr phases, in-order checks
module tb_top;

   typedef struct {
      logic signed [15:0] tgt [4];
      logic signed [15:0] rot [4];
      logic [11:0]        pwr;
      logic [9:0]         benergy;
   } wheel_beat_type;

   typedef struct {
      logic signed [15:0] cur [4];
      logic               byp;
   } current_cmd_type;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_target_a = '0, req_target_b = '0, req_target_c = '0,
                       req_target_d = '0;
   logic signed [15:0] req_rotor_a = '0, req_rotor_b = '0, req_rotor_c = '0,
                       req_rotor_d = '0;
   logic [11:0] req_power_now = '0;
   logic [9:0]  req_buffer_energy = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_current_a, rsp_current_b, rsp_current_c, rsp_current_d;
   logic rsp_bypass;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = wcpl_pkg::CSR_TOTAL_ERROR_LIMIT;
   logic [17:0] csr_wdata = '0;

   wheel_current_power_limiter u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [17:0] err_limit_q;
   logic [11:0] power_thr_q;
   logic [15:0] full_scale_q;

   wheel_beat_type  pending_beats [$];
   current_cmd_type expected_cmds [$];
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  quiet_end = 0;

   function automatic logic [16:0] energy_factor(logic [9:0] e);
      if (e >= 40 && e < 50) return 17'd58982;
      if (e >= 35 && e < 40) return 17'd49152;
      if (e >= 30 && e < 35) return 17'd32768;
      if (e >= 20 && e < 30) return 17'd16384;
      if (e >= 10 && e < 20) return 17'd8192;
      if (e >= 1 && e < 10) return 17'd3277;
      return 17'd65536;
   endfunction

   function automatic current_cmd_type share_currents(wheel_beat_type b);
      current_cmd_type r;
      longint err [4];
      longint total, gain, scaled, budget, mag, q;
      total = 0;
      for (int i = 0; i < 4; i++) begin
         err[i] = longint'(b.tgt[i]) - longint'(b.rot[i]);
         total += (err[i] < 0) ? -err[i] : err[i];
      end
      r.byp = 1'b0;
      for (int i = 0; i < 4; i++) r.cur[i] = '0;
      if (b.pwr > power_thr_q) begin
         r.byp = 1'b1;
         return r;
      end
      if (total >= longint'(err_limit_q)) gain = 65536;
      else gain = (total << 16) / longint'(err_limit_q);
      scaled = (longint'(full_scale_q) * gain) >> 16;
      budget = (scaled * longint'(energy_factor(b.benergy))) >> 16;
      if (total != 0) begin
         for (int i = 0; i < 4; i++) begin
            mag = (err[i] < 0) ? -err[i] : err[i];
            q = (mag * budget) / total;
            if (err[i] < 0) r.cur[i] = (q > 32768) ? -16'sd32768 : 16'(-q);
            else r.cur[i] = (q > 32767) ? 16'sd32767 : 16'(q);
         end
      end
      return r;
   endfunction

   bit   req_taken = 0;
   int   req_idle = 0;
   int   rsp_idle = 0;

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (req_idle > 0) begin
               req_idle <= req_idle - 1;
               req_valid <= 1'b0;
            end else if (!quiet_end && $urandom_range(0, 9) == 0) begin
               req_idle <= $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               wheel_beat_type b;
               b = pending_beats.pop_front();
               expected_cmds.push_back(share_currents(b));
               req_target_a <= b.tgt[0]; req_target_b <= b.tgt[1];
               req_target_c <= b.tgt[2]; req_target_d <= b.tgt[3];
               req_rotor_a <= b.rot[0]; req_rotor_b <= b.rot[1];
               req_rotor_c <= b.rot[2]; req_rotor_d <= b.rot[3];
               req_power_now <= b.pwr;
               req_buffer_energy <= b.benergy;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_idle > 0) begin
            rsp_idle <= rsp_idle - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_end && $urandom_range(0, 9) == 0) begin
            rsp_idle <= $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && rsp_valid && !rsp_stall) begin
         current_cmd_type got, want;
         got.cur[0] = rsp_current_a; got.cur[1] = rsp_current_b;
         got.cur[2] = rsp_current_c; got.cur[3] = rsp_current_d;
         got.byp = rsp_bypass;
         if (expected_cmds.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected response beat");
         end else begin
            want = expected_cmds.pop_front();
            if (got.byp !== want.byp || got.cur[0] !== want.cur[0]
                || got.cur[1] !== want.cur[1] || got.cur[2] !== want.cur[2]
                || got.cur[3] !== want.cur[3]) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: exp %0d %0d %0d %0d byp %0b, got %0d %0d %0d %0d byp %0b",
                           want.cur[0], want.cur[1], want.cur[2], want.cur[3], want.byp,
                           got.cur[0], got.cur[1], got.cur[2], got.cur[3], got.byp);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [17:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         wcpl_pkg::CSR_TOTAL_ERROR_LIMIT:  err_limit_q = val;
         wcpl_pkg::CSR_POWER_THRESHOLD:    power_thr_q = val[11:0];
         wcpl_pkg::CSR_FULL_SCALE_CURRENT: full_scale_q = val[15:0];
         default: ;
      endcase
   endtask

   task automatic add_beat(int t0, int t1, int t2, int t3, int r0, int r1, int r2, int r3,
                           int p, int e);
      wheel_beat_type b;
      b.tgt[0] = 16'(t0); b.tgt[1] = 16'(t1); b.tgt[2] = 16'(t2); b.tgt[3] = 16'(t3);
      b.rot[0] = 16'(r0); b.rot[1] = 16'(r1); b.rot[2] = 16'(r2); b.rot[3] = 16'(r3);
      b.pwr = 12'(p); b.benergy = 10'(e);
      pending_beats.push_back(b);
   endtask

   task automatic add_random_beat();
      int t [4];
      int r [4];
      int span;
      span = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         t[i] = int'($signed(16'($urandom)));
         case (span)
            0: r[i] = t[i] - (int'($urandom_range(0, 200)) - 100);
            1: r[i] = t[i] - (int'($urandom_range(0, 12000)) - 6000);
            default: r[i] = int'($signed(16'($urandom)));
         endcase
      end
      add_beat(t[0], t[1], t[2], t[3], r[0], r[1], r[2], r[3],
               ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095))
                                           : int'($urandom_range(0, 700)),
               ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 60))
                                           : int'($urandom_range(0, 1023)));
   endtask

   task automatic drain();
      wait (pending_beats.size() == 0 && expected_cmds.size() == 0);
      repeat (wcpl_pkg::LAT + 10) @(posedge clock);
   endtask

   initial begin
      err_limit_q  = wcpl_pkg::RST_TOTAL_ERROR_LIMIT;
      power_thr_q  = wcpl_pkg::RST_POWER_THRESHOLD;
      full_scale_q = wcpl_pkg::RST_FULL_SCALE_CURRENT;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats at reset settings
      add_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(32767, -32768, 100, -100, -32768, 32767, 0, 0, 0, 0);
      add_beat(-32768, 32767, 5, 5, 32767, -32768, 5, 5, 600, 1023);
      add_beat(10, 0, 0, 0, 0, 0, 0, 0, 601, 50);
      add_beat(1, 2, 3, 4, 0, 0, 0, 0, 4095, 49);
      for (int e = 0; e < 7; e++)
         add_beat(5000, -4000, 3000, -2000, 0, 0, 0, 0, 1445,
                  e == 0 ? 45 : e == 1 ? 37 : e == 2 ? 30 : e == 3 ? 29 :
                  e == 4 ? 10 : e == 5 ? 9 : 1);
      add_beat(100, -100, 0, 0, 0, 0, 0, 0, 0, 1);
      drain();

      csr_write(wcpl_pkg::CSR_TOTAL_ERROR_LIMIT, 18'd1);
      csr_write(wcpl_pkg::CSR_POWER_THRESHOLD, 18'd4095);
      csr_write(wcpl_pkg::CSR_FULL_SCALE_CURRENT, 18'd65535);
      add_beat(32767, 0, 0, 0, -32768, 0, 0, 0, 4095, 0);
      add_beat(1, 0, 0, 0, 0, 0, 0, 0, 4095, 1023);
      add_beat(-1, 1, 0, 0, 0, 0, 0, 0, 2048, 512);
      add_beat(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 0, 0);
      drain();

      csr_write(wcpl_pkg::CSR_TOTAL_ERROR_LIMIT, 18'h3ffff);
      csr_write(wcpl_pkg::CSR_POWER_THRESHOLD, 18'd0);
      csr_write(wcpl_pkg::CSR_FULL_SCALE_CURRENT, 18'd0);
      add_beat(300, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(300, 0, 0, 0, 0, 0, 0, 0, 1, 0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               csr_write(wcpl_pkg::CSR_TOTAL_ERROR_LIMIT,
                         18'(wcpl_pkg::RST_TOTAL_ERROR_LIMIT));
               csr_write(wcpl_pkg::CSR_POWER_THRESHOLD,
                         18'(wcpl_pkg::RST_POWER_THRESHOLD));
               csr_write(wcpl_pkg::CSR_FULL_SCALE_CURRENT,
                         18'(wcpl_pkg::RST_FULL_SCALE_CURRENT));
            end
            1: begin
               csr_write(wcpl_pkg::CSR_TOTAL_ERROR_LIMIT, 18'h3ffff);
               csr_write(wcpl_pkg::CSR_POWER_THRESHOLD, 18'd4095);
               csr_write(wcpl_pkg::CSR_FULL_SCALE_CURRENT, 18'd65535);
            end
            default: begin
               csr_write(wcpl_pkg::CSR_TOTAL_ERROR_LIMIT, 18'($urandom_range(1, 262143)));
               csr_write(wcpl_pkg::CSR_POWER_THRESHOLD, 18'($urandom_range(0, 4095)));
               csr_write(wcpl_pkg::CSR_FULL_SCALE_CURRENT, 18'($urandom_range(0, 65535)));
            end
         endcase
         if (phase == 3) quiet_end = 1;
         for (int n = 0; n < 125; n++) add_random_beat();
         drain();
      end

      if (mismatches == 0 && expected_cmds.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/wcpl_pkg.sv
hw/rtl/wcpl_kdiv.sv
hw/rtl/wcpl_lane.sv
hw/rtl/wheel_current_power_limiter.sv
verif/tb_top.sv
